>>> hw/rtl/nsfc_pkg.sv
package nsfc_pkg;

	localparam int MAX_LEN_DEF = 82;

	localparam logic [7:0] START_CHAR_RST = 8'h21;
	localparam logic [7:0] CHAR_STAR      = 8'h2A;
	localparam logic [7:0] CHAR_COMMA     = 8'h2C;
	localparam logic [6:0] FIELD_CAP      = 7'd126;

	typedef enum logic {
		KIND_CHAR   = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_MISMATCH = 2'd1,
		ST_BAD_HEX  = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] char_value;
		logic [6:0] field_index;
		status_t    status;
		logic [7:0] received_sum;
		logic [7:0] computed_sum;
		logic [6:0] body_length;
		logic [6:0] field_count;
	} result_t;

	// Space, tab, LF, VT, FF, CR and NUL end the emitted part of a body.
	function automatic logic is_stop(input logic [7:0] b);
		return (b == 8'h00) || (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
	endfunction

	// Returns the digit value in the low four bits and a bad-digit flag on top.
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [7:0] d;
		d = 8'h00;
		if ((b >= 8'h30) && (b <= 8'h39)) begin
			d = b - 8'h30;
			return {1'b0, d[3:0]};
		end
		if ((b >= 8'h41) && (b <= 8'h46)) begin
			d = b - 8'h37;
			return {1'b0, d[3:0]};
		end
		if ((b >= 8'h61) && (b <= 8'h66)) begin
			d = b - 8'h57;
			return {1'b0, d[3:0]};
		end
		return {1'b1, 4'h0};
	endfunction

endpackage

>>> hw/rtl/nsfc_in_reg.sv
module nsfc_in_reg
	import nsfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic valid_q_s1;

	// The stage holds its byte until the core consumes it.
	assign in_stall = valid_q_s1 && !advance;
	assign valid_s1 = valid_q_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_q_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

>>> hw/rtl/nsfc_core.sv
module nsfc_core
	import nsfc_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       advance,
	input  logic [7:0] byte_s1,
	output logic       res_valid,
	output result_t    res
);

	typedef enum logic [1:0] {
		PH_WAIT,
		PH_BODY,
		PH_DIGIT_HI,
		PH_DIGIT_LO
	} phase_t;

	localparam logic [6:0] MaxLen = 7'(MAX_LEN);

	phase_t     phase_q, phase_d;
	logic [7:0] start_char_q;
	logic [7:0] sum_q, sum_d;
	logic [6:0] len_q, len_d;
	logic [6:0] field_q, field_d;
	logic [3:0] first_digit_q, first_digit_d;
	logic       bad_hex_q, bad_hex_d;
	logic       overflow_q, overflow_d;
	logic       stopped_q, stopped_d;
	logic [4:0] hex;
	logic [7:0] rx_sum;

	assign hex    = hex_decode(byte_s1);
	assign rx_sum = {first_digit_q, hex[3:0]};

	always_comb begin
		phase_d       = phase_q;
		sum_d         = sum_q;
		len_d         = len_q;
		field_d       = field_q;
		first_digit_d = first_digit_q;
		bad_hex_d     = bad_hex_q;
		overflow_d    = overflow_q;
		stopped_d     = stopped_q;
		res_valid     = 1'b0;
		res           = '0;
		case (phase_q)
			PH_WAIT: begin
				if (byte_s1 == start_char_q) begin
					phase_d       = PH_BODY;
					sum_d         = 8'h00;
					len_d         = 7'd0;
					field_d       = 7'd0;
					first_digit_d = 4'h0;
					bad_hex_d     = 1'b0;
					overflow_d    = 1'b0;
					stopped_d     = 1'b0;
				end
			end
			PH_BODY: begin
				if (byte_s1 == CHAR_STAR) begin
					phase_d = PH_DIGIT_HI;
				end else begin
					sum_d = sum_q ^ byte_s1;
					if (len_q >= MaxLen) begin
						overflow_d = 1'b1;
					end else begin
						len_d = len_q + 7'd1;
						if (!stopped_q) begin
							if (is_stop(byte_s1)) begin
								stopped_d = 1'b1;
							end else begin
								res_valid       = 1'b1;
								res.kind        = KIND_CHAR;
								res.char_value  = byte_s1;
								res.field_index = field_q;
								if ((byte_s1 == CHAR_COMMA) && (field_q < FIELD_CAP)) begin
									field_d = field_q + 7'd1;
								end
							end
						end
					end
				end
			end
			PH_DIGIT_HI: begin
				first_digit_d = hex[3:0];
				bad_hex_d     = bad_hex_q | hex[4];
				phase_d       = PH_DIGIT_LO;
			end
			PH_DIGIT_LO: begin
				bad_hex_d          = bad_hex_q | hex[4];
				res_valid          = 1'b1;
				res.kind           = KIND_STATUS;
				res.received_sum   = rx_sum;
				res.computed_sum   = sum_q;
				res.body_length    = len_q;
				res.field_count    = field_q + 7'd1;
				if (overflow_q) begin
					res.status = ST_OVERFLOW;
				end else if (bad_hex_q || hex[4]) begin
					res.status = ST_BAD_HEX;
				end else if (rx_sum != sum_q) begin
					res.status = ST_MISMATCH;
				end else begin
					res.status = ST_OK;
				end
				phase_d = PH_WAIT;
			end
			default: begin
				phase_d = PH_WAIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_char_q <= START_CHAR_RST;
		end else if (cfg_wr_en) begin
			start_char_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_WAIT;
			sum_q         <= 8'h00;
			len_q         <= 7'd0;
			field_q       <= 7'd0;
			first_digit_q <= 4'h0;
			bad_hex_q     <= 1'b0;
			overflow_q    <= 1'b0;
			stopped_q     <= 1'b0;
		end else if (advance) begin
			phase_q       <= phase_d;
			sum_q         <= sum_d;
			len_q         <= len_d;
			field_q       <= field_d;
			first_digit_q <= first_digit_d;
			bad_hex_q     <= bad_hex_d;
			overflow_q    <= overflow_d;
			stopped_q     <= stopped_d;
		end
	end

endmodule

>>> hw/rtl/nsfc_out_reg.sv
module nsfc_out_reg
	import nsfc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid_s1,
	input  logic    res_valid,
	input  result_t res,
	input  logic    out_stall,
	output logic    out_valid,
	output logic    advance,
	output result_t res_q
);

	logic out_valid_q;

	// The byte in the input stage moves on whenever the result slot is free
	// or is being emptied in this cycle.
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

endmodule

>>> hw/rtl/nmea_sentence_framer_checksum.sv
// Sentence framer and XOR checksum checker for NMEA 0183 style sentences.
//
// Input channel: one received byte per transaction on rx_byte, taken when
// in_valid is high and in_stall is low. Outside a sentence the block waits
// for start_char ('!' after reset); the body runs up to '*', and the two
// hex digits after '*' close the sentence.
// Output channel: a transaction moves when out_valid is high and out_stall
// is low. A kind 0 transaction carries one body byte and its field index;
// a kind 1 transaction carries the end-of-sentence status with the parsed
// and computed checksums, the stored body length and the field count.
// Some bytes, such as those outside a sentence, cause no output transaction at all.
// Path: an accepted byte goes into the input register, and its result into
// the result register, which drives out_valid. Throughput is one byte per
// cycle while the receiver does not stall.
// When the receiver stalls, the held result stays unchanged; at most one
// more byte is taken into the input register, and then in_stall rises until the
// result register drains.
// Reset clears all sentence state and both pipeline valid flags and sets
// start_char back to '!'. Write start_char only while the block is idle.
module nmea_sentence_framer_checksum
	import nsfc_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       kind,
	output logic [7:0] char_value,
	output logic [6:0] field_index,
	output logic [1:0] status,
	output logic [7:0] received_sum,
	output logic [7:0] computed_sum,
	output logic [6:0] body_length,
	output logic [6:0] field_count
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       res_valid;
	result_t    res;
	result_t    res_q;

	// Input register: holds one byte ahead of the core and stalls the sender while that byte cannot advance.
	nsfc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// Sentence state and the per-byte update, one byte per cycle while advance is high.
	nsfc_core #(
		.MAX_LEN (MAX_LEN)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.advance     (advance),
		.byte_s1     (byte_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Result register: holds a transaction until the receiver takes it.
	nsfc_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res_valid (res_valid),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.advance   (advance),
		.res_q     (res_q)
	);

	assign kind         = res_q.kind;
	assign char_value   = res_q.char_value;
	assign field_index  = res_q.field_index;
	assign status       = res_q.status;
	assign received_sum = res_q.received_sum;
	assign computed_sum = res_q.computed_sum;
	assign body_length  = res_q.body_length;
	assign field_count  = res_q.field_count;

endmodule
